// ===== rtl/lru_page_replacement_unit_macros.svh =====
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LRUPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_NUMBER_W = 16;
    localparam int FRAME_INDEX_W = 4;
    localparam int EVICTED_PAGE_W = 16;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/lrupr_ref_if.sv =====
`default_nettype none

interface lrupr_ref_if;
    import lrupr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PAGE_NUMBER_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrupr_res_if.sv =====
`default_nettype none

interface lrupr_res_if;
    import lrupr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [FRAME_INDEX_W-1:0]  frame_index;
    logic                      evicted_valid;
    logic [EVICTED_PAGE_W-1:0] evicted_page;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, input ready);
    modport sink (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrupr_cell.sv =====
`default_nettype none

module lrupr_cell #(
    parameter int IDX        = 0,
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    parameter int AGE_BITS   = 16,
    localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int TOK_W     = 4 + 2 * PAGE_BITS + 3 * IDX_W + AGE_BITS,
    localparam int UPD_W     = 2 + IDX_W + PAGE_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             active,
    input  wire logic [TOK_W-1:0] tok_i,
    output logic      [TOK_W-1:0] tok_o,
    input  wire logic [UPD_W-1:0] upd_i
);
    import lrupr_pkg::*;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [IDX_W-1:0]     found_idx;
        logic                 have_empty;
        logic [IDX_W-1:0]     empty_idx;
        logic                 best_set;
        logic [IDX_W-1:0]     best_idx;
        logic [AGE_BITS-1:0]  best_age;
        logic [PAGE_BITS-1:0] best_page;
    } tok_t;

    typedef struct packed {
        logic                 en;
        logic                 hit;
        logic [IDX_W-1:0]     slot;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    localparam logic [IDX_W-1:0]    IDX_C   = IDX_W'(IDX);
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    tok_t                 tin;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    upd_t                 upd;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [AGE_BITS-1:0]  age_reg;
    logic [AGE_BITS-1:0]  age_next;
    logic                 match;

    assign tin   = tok_t'(tok_i);
    assign upd   = upd_t'(upd_i);
    assign tok_o = TOK_W'(tok_reg);
    assign match = active && valid_reg && (page_reg == tin.page);

    // search step: first match, first empty, oldest so far
    always_comb
    begin
        tok_next = tin;
        if (match && !tin.found)
        begin
            tok_next.found     = 1'b1;
            tok_next.found_idx = IDX_C;
        end
        if (active && !valid_reg && !tin.have_empty)
        begin
            tok_next.have_empty = 1'b1;
            tok_next.empty_idx  = IDX_C;
        end
        if (active && (!tin.best_set || (age_reg > tin.best_age)))
        begin
            tok_next.best_set  = 1'b1;
            tok_next.best_idx  = IDX_C;
            tok_next.best_age  = age_reg;
            tok_next.best_page = page_reg;
        end
    end

    // frame update on the broadcast decision
    always_comb
    begin
        age_next   = age_reg;
        valid_next = valid_reg;
        page_next  = page_reg;
        if (upd.en && active)
        begin
            if (upd.slot == IDX_C)
            begin
                age_next = AGE_ONE;
            end
            else if (age_reg != AGE_MAX)
            begin
                age_next = age_reg + AGE_ONE;
            end
            if (!upd.hit && (upd.slot == IDX_C))
            begin
                valid_next = 1'b1;
                page_next  = upd.page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
            age_reg   <= AGE_ONE;
        end
        else
        begin
            tok_reg   <= tok_next;
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_unit.sv =====
// LRU page replacement with per-frame age counters.
// page_in (sink): one page_number per transfer. page_res (source): one result
// per reference with hit, frame_index, evicted_valid and evicted_page.
// cfg_we/cfg_wdata write frames_in_use (0 acts as 1, above MAX_FRAMES acts as
// MAX_FRAMES); write it only while no reference is in flight.
// A reference travels down a row of MAX_FRAMES frame cells, one cell per cycle,
// collecting the first match, the first empty frame and the oldest frame.
// A finished search waits in a pending register; when it moves on, the decision
// is broadcast to all cells, and the active ones age and load while the result
// enters the output register. Only one reference is in flight: page_in.ready
// is low from a transfer until its result enters the output register.
// Receiver stall: the result holds in the output register; a finished search
// waits in a pending register and the frames are not updated until it moves.
// Reset: all frames invalid, all ages 1, frames_in_use 16, no result pending.
`default_nettype none
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16,
    parameter int AGE_BITS   = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
    lrupr_ref_if.sink                    page_in,
    lrupr_res_if.source                  page_res
);
    import lrupr_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TOK_W = 4 + 2 * PAGE_BITS + 3 * IDX_W + AGE_BITS;
    localparam int UPD_W = 2 + IDX_W + PAGE_BITS;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [IDX_W-1:0]     found_idx;
        logic                 have_empty;
        logic [IDX_W-1:0]     empty_idx;
        logic                 best_set;
        logic [IDX_W-1:0]     best_idx;
        logic [AGE_BITS-1:0]  best_age;
        logic [PAGE_BITS-1:0] best_page;
    } tok_t;

    typedef struct packed {
        logic                 en;
        logic                 hit;
        logic [IDX_W-1:0]     slot;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    logic [CFG_W-1:0]          frames_in_use_reg;
    logic [CNT_W-1:0]          active_cnt;
    logic [MAX_FRAMES-1:0]     active;
    logic [TOK_W-1:0]          chain [MAX_FRAMES+1];
    logic [MAX_FRAMES-1:0]     chain_valid;
    tok_t                      head;
    tok_t                      tail;
    tok_t                      pend_reg;
    logic                      pend_valid_reg;
    logic                      busy_reg;
    logic                      fin;
    logic [IDX_W-1:0]          slot_sel;
    logic                      evict;
    upd_t                      upd;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [FRAME_INDEX_W-1:0]  frame_index_reg;
    logic                      evicted_valid_reg;
    logic [EVICTED_PAGE_W-1:0] evicted_page_reg;

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            active_cnt = CNT_W'(1);
        end
        else if (32'(frames_in_use_reg) > 32'(MAX_FRAMES))
        begin
            active_cnt = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            active_cnt = CNT_W'(frames_in_use_reg);
        end
    end

    assign page_in.ready = !busy_reg;

    always_comb
    begin
        head       = '0;
        head.valid = page_in.valid && page_in.ready;
        head.page  = PAGE_BITS'(page_in.page_number);
    end

    assign chain[0] = TOK_W'(head);

    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_cell
        tok_t cell_tok;

        assign active[i]      = (active_cnt > CNT_W'(i));
        assign cell_tok       = tok_t'(chain[i+1]);
        assign chain_valid[i] = cell_tok.valid;

        lrupr_cell #(
            .IDX        (i),
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .AGE_BITS   (AGE_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .active (active[i]),
            .tok_i  (chain[i]),
            .tok_o  (chain[i+1]),
            .upd_i  (UPD_W'(upd))
        );
    end

    assign tail = tok_t'(chain[MAX_FRAMES]);
    assign fin  = pend_valid_reg && (!out_valid_reg || page_res.ready);

    always_comb
    begin
        if (pend_reg.found)
        begin
            slot_sel = pend_reg.found_idx;
        end
        else if (pend_reg.have_empty)
        begin
            slot_sel = pend_reg.empty_idx;
        end
        else
        begin
            slot_sel = pend_reg.best_idx;
        end
        evict    = !pend_reg.found && !pend_reg.have_empty;
        upd.en   = fin;
        upd.hit  = pend_reg.found;
        upd.slot = slot_sel;
        upd.page = pend_reg.page;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            busy_reg          <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            if (head.valid)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end
            if (tail.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (page_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            pend_reg <= tail;
        end
        if (fin)
        begin
            hit_reg           <= pend_reg.found;
            frame_index_reg   <= FRAME_INDEX_W'(slot_sel);
            evicted_valid_reg <= evict;
            evicted_page_reg  <= evict ? EVICTED_PAGE_W'(pend_reg.best_page) : '0;
        end
    end

    assign page_res.valid         = out_valid_reg;
    assign page_res.hit           = hit_reg;
    assign page_res.frame_index   = frame_index_reg;
    assign page_res.evicted_valid = evicted_valid_reg;
    assign page_res.evicted_page  = evicted_page_reg;

    `LRUPR_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, page_in.valid && page_in.ready,
        busy_reg, "busy not set after input transfer")
    `LRUPR_ASSERT_SAME(a_single_token, clk, rst_n, 1'b1,
        $countones({chain_valid, pend_valid_reg}) <= 1, "more than one reference in flight")
    `LRUPR_ASSERT_SAME(a_idle_when_ready, clk, rst_n, page_in.ready,
        (chain_valid == '0) && !pend_valid_reg, "ready while a reference is in flight")
    `LRUPR_ASSERT_SAME(a_slot_in_use, clk, rst_n, fin,
        active_cnt > CNT_W'(slot_sel), "chosen frame outside frames in use")
    `LRUPR_ASSERT_NEXT(a_result_after_fin, clk, rst_n, fin,
        out_valid_reg && !busy_reg, "result not registered after decision")

endmodule

`default_nettype wire

// ===== tb/sv/lru_page_replacement_unit_tb.sv =====
`default_nettype none

module lru_page_replacement_unit_tb;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES = 16;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef struct packed {
        logic                      hit;
        logic [FRAME_INDEX_W-1:0]  frame_index;
        logic                      evicted_valid;
        logic [EVICTED_PAGE_W-1:0] evicted_page;
    } lookup_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lrupr_ref_if page_ch ();
    lrupr_res_if result_ch ();

    lru_page_replacement_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .page_in  (page_ch),
        .page_res (result_ch)
    );

    // page table shadow
    logic [PAGE_NUMBER_W-1:0] shadow_page [MAX_FRAMES];
    bit                       shadow_valid[MAX_FRAMES];
    logic [15:0]              shadow_age  [MAX_FRAMES];
    logic [CFG_W-1:0]         shadow_frames;

    lookup_t pending_lookups[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(12 * 600000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic lookup_t resolve_reference(input logic [PAGE_NUMBER_W-1:0] page);
        lookup_t r;
        int      count;
        int      slot;
        bit      found;
        bit      have_empty;
        begin
            count = (shadow_frames == 0) ? 1 :
                    (shadow_frames > MAX_FRAMES) ? MAX_FRAMES : int'(shadow_frames);
            r = '0;
            slot = 0;
            found = 1'b0;
            have_empty = 1'b0;
            for (int i = 0; i < count; i++)
            begin
                if (!found && shadow_valid[i] && shadow_page[i] == page)
                begin
                    slot = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                for (int i = 0; i < count; i++)
                begin
                    if (!have_empty && !shadow_valid[i])
                    begin
                        slot = i;
                        have_empty = 1'b1;
                    end
                end
                if (!have_empty)
                begin
                    slot = 0;
                    for (int i = 1; i < count; i++)
                    begin
                        if (shadow_age[i] > shadow_age[slot])
                            slot = i;
                    end
                end
                r.evicted_valid = shadow_valid[slot];
                r.evicted_page = shadow_valid[slot] ? shadow_page[slot] : '0;
                shadow_page[slot] = page;
                shadow_valid[slot] = 1'b1;
            end
            r.hit = found;
            r.frame_index = slot[FRAME_INDEX_W-1:0];
            for (int i = 0; i < count; i++)
            begin
                if (shadow_age[i] < AGE_MAX)
                    shadow_age[i] = shadow_age[i] + 16'd1;
            end
            shadow_age[slot] = 16'd1;
            return r;
        end
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        end
    endfunction

    // receiver side
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : monitor
        lookup_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual frame %0d", $time,
                             result_ch.frame_index);
                    errors++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    check_field("hit", 16'(want.hit), 16'(result_ch.hit));
                    check_field("frame_index", 16'(want.frame_index),
                                16'(result_ch.frame_index));
                    check_field("evicted_valid", 16'(want.evicted_valid),
                                16'(result_ch.evicted_valid));
                    check_field("evicted_page", want.evicted_page, result_ch.evicted_page);
                end
            end
            if (page_ch.valid && page_ch.ready)
                pending_lookups.push_back(resolve_reference(page_ch.page_number));
            if (cfg_we)
                shadow_frames = cfg_wdata;
        end
    end

    task automatic send_page(input logic [PAGE_NUMBER_W-1:0] page);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                page_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
            page_ch.valid <= 1'b1;
            page_ch.page_number <= page;
            @(posedge clk);
            while (!(page_ch.valid && page_ch.ready))
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        begin
            page_ch.valid <= 1'b0;
            while (pending_lookups.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        begin
            wait_for_results();
            cfg_we <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic test_fill_and_hit();
        begin
            send_page(16'h0000);
            send_page(16'hFFFF);
            send_page(16'h0000);
            send_page(16'hFFFF);
            send_page(16'h5555);
            send_page(16'hAAAA);
            for (int i = 0; i < 10; i++)
                send_page(PAGE_NUMBER_W'(16'h0100 + i));
            // two frames still empty: new pages take them, then earlier pages hit
            send_page(16'h0200);
            send_page(16'h0001);
            send_page(16'h5555);
            send_page(16'h0000);
        end
    endtask

    task automatic test_frame_count();
        begin
            set_frames(5'd1);
            send_page(16'h0007);
            send_page(16'h0007);
            send_page(16'h0008);
            // zero acts as one frame
            set_frames(5'd0);
            send_page(16'h0008);
            send_page(16'h0009);
            // above the built count saturates
            set_frames(5'd31);
            send_page(16'hAAAA);
            send_page(16'hFFFF);
            set_frames(5'd17);
            send_page(16'h0105);
            // frames outside the count are kept but not searched
            set_frames(5'd4);
            send_page(16'h0300);
            send_page(16'h0301);
            send_page(16'h0109);
            set_frames(5'd16);
            send_page(16'h0105);
            send_page(16'h0109);
        end
    endtask

    task automatic test_random(input int items, input int send_pct, input int recv_pct);
        logic [CFG_W-1:0]         frames;
        logic [PAGE_NUMBER_W-1:0] base;
        logic [PAGE_NUMBER_W-1:0] page;
        int                       span;
        int                       mode;
        begin
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            for (int n = 0; n < items; n += 50)
            begin
                case ($urandom_range(5))
                    0: frames = 5'd1;
                    1: frames = 5'd16;
                    2: frames = 5'd31;
                    3: frames = 5'd0;
                    default: frames = CFG_W'($urandom_range(31));
                endcase
                set_frames(frames);
                base = PAGE_NUMBER_W'($urandom);
                span = $urandom_range(1, 20);
                for (int k = 0; k < 50; k++)
                begin
                    mode = $urandom_range(99);
                    if (mode < 10)
                        page = PAGE_NUMBER_W'($urandom);
                    else if (mode < 40)
                        page = base + PAGE_NUMBER_W'(k % span);
                    else
                        page = base + PAGE_NUMBER_W'($urandom_range(span - 1));
                    send_page(page);
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        page_ch.valid = 1'b0;
        page_ch.page_number = '0;
        result_ch.ready = 1'b0;
        shadow_frames = FRAMES_IN_USE_RESET;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            shadow_page[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_age[i] = 16'd1;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_hit();
        test_frame_count();
        test_random(300, 18, 75);
        test_random(300, 75, 18);
        test_random(300, 0, 0);

        wait_for_results();
        repeat (MAX_FRAMES + 4) @(negedge clk);
        if (pending_lookups.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_lookups.size());
            errors++;
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
